/* rtl/core/idiv_pkg.sv */
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared types and constants of the pipelined restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package idiv_pkg;

  localparam int unsigned IDIV_DATA_WIDTH = 64;

  typedef enum logic [1:0] {
    MODE_UQUO = 2'd0,
    MODE_UREM = 2'd1,
    MODE_SQUO = 2'd2,
    MODE_SREM = 2'd3
  } mode_e;

  typedef struct packed {
    logic rem_sel;
    logic negate;
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/idiv_if.sv */
// ----------------------------------------------------------------------------
// idiv_if
// Request and response channels of the divider (valid/ready beats).
// ----------------------------------------------------------------------------
`default_nettype none

interface idiv_req_if #(
  parameter int unsigned DATA_WIDTH = 64
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  modport source (output valid, mode, dividend, divisor, input ready);
  modport sink   (input valid, mode, dividend, divisor, output ready);
endinterface

interface idiv_rsp_if #(
  parameter int unsigned DATA_WIDTH = 64
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

/* rtl/core/idiv_pre.sv */
// ----------------------------------------------------------------------------
// idiv_pre
// Input stage: decodes the mode and turns signed operands into magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_pre import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = IDIV_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  idiv_req_if.sink              req_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ctl_t                  ctl_o,
  output logic [DATA_WIDTH-1:0] num_o,
  output logic [DATA_WIDTH-1:0] den_o
);

  mode_e                 mode;
  logic                  is_signed;
  logic                  num_neg;
  logic                  den_neg;
  ctl_t                  ctl_d;
  logic [DATA_WIDTH-1:0] num_d;
  logic [DATA_WIDTH-1:0] den_d;
  logic                  valid_q;
  ctl_t                  ctl_q;
  logic [DATA_WIDTH-1:0] num_q;
  logic [DATA_WIDTH-1:0] den_q;

  assign mode = mode_e'(req_i.mode);

  always_comb begin
    case (mode)
      MODE_SQUO, MODE_SREM: is_signed = 1'b1;
      default:              is_signed = 1'b0;
    endcase
    num_neg       = is_signed & req_i.dividend[DATA_WIDTH-1];
    den_neg       = is_signed & req_i.divisor[DATA_WIDTH-1];
    num_d         = num_neg ? ({DATA_WIDTH{1'b0}} - req_i.dividend) : req_i.dividend;
    den_d         = den_neg ? ({DATA_WIDTH{1'b0}} - req_i.divisor) : req_i.divisor;
    ctl_d.rem_sel = (mode inside {MODE_UREM, MODE_SREM});
    ctl_d.negate  = ctl_d.rem_sel ? num_neg : (num_neg ^ den_neg);
  end

  assign req_i.ready = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      ctl_q <= ctl_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

/* rtl/core/idiv_cell.sv */
// ----------------------------------------------------------------------------
// idiv_cell
// One quotient bit: shift in the next dividend bit, trial-subtract, restore.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_cell import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = IDIV_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ctl_t                  ctl_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ctl_t                  ctl_o,
  output logic [DATA_WIDTH-1:0] den_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] nq_o
);

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_d;
  logic [DATA_WIDTH-1:0] nq_d;
  logic                  valid_q;
  ctl_t                  ctl_q;
  logic [DATA_WIDTH-1:0] den_q;
  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH-1:0] nq_q;

  always_comb begin
    trial = {rem_i, nq_i[DATA_WIDTH-1]};
    diff  = {1'b0, trial} - {2'b00, den_i};
    ge    = ~diff[DATA_WIDTH+1];
    rem_d = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    nq_d  = {nq_i[DATA_WIDTH-2:0], ge};
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q <= ctl_i;
      den_q <= den_i;
      rem_q <= rem_d;
      nq_q  <= nq_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;

endmodule

`default_nettype wire

/* rtl/core/idiv_post.sv */
// ----------------------------------------------------------------------------
// idiv_post
// Output stage: selects quotient or remainder and applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_post import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = IDIV_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ctl_t                  ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  idiv_rsp_if.source            rsp_o
);

  logic [DATA_WIDTH-1:0] sel;
  logic [DATA_WIDTH-1:0] result_d;
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] result_q;

  always_comb begin
    sel      = ctl_i.rem_sel ? rem_i : quo_i;
    result_d = ctl_i.negate ? ({DATA_WIDTH{1'b0}} - sel) : sel;
  end

  assign ready_o = ~valid_q | rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
    end
  end

  assign rsp_o.valid  = valid_q;
  assign rsp_o.result = result_q;

endmodule

`default_nettype wire

/* rtl/core/integer_divider_64_top.sv */
// ----------------------------------------------------------------------------
// integer_divider_64_top
// Fully pipelined restoring divider: quotient or remainder, signed or not.
// ----------------------------------------------------------------------------
// Without response stalls, one request beat is accepted per clock and one
// response beat leaves per clock. Each beat passes in turn through one
// input stage that takes operand magnitudes, one cell per quotient bit,
// each doing one DATA_WIDTH+1 bit trial subtract, and one output stage
// that selects and signs the result. Every stage has its own valid bit,
// so bubbles close up while the response side stalls. Division by zero
// gives an all-ones quotient and the dividend as remainder, signed as usual.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_divider_64_top import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = IDIV_DATA_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idiv_req_if.sink   req_i,
  idiv_rsp_if.source rsp_o
);

  logic                  valid_s [DATA_WIDTH+1];
  logic                  ready_s [DATA_WIDTH+1];
  ctl_t                  ctl_s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den_s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem_s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] nq_s    [DATA_WIDTH+1];

  idiv_pre #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_pre (
    .clk_i,
    .rst_ni,
    .req_i,
    .valid_o(valid_s[0]),
    .ready_i(ready_s[0]),
    .ctl_o  (ctl_s[0]),
    .num_o  (nq_s[0]),
    .den_o  (den_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    idiv_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .valid_i(valid_s[i]),
      .ready_o(ready_s[i]),
      .ctl_i  (ctl_s[i]),
      .den_i  (den_s[i]),
      .rem_i  (rem_s[i]),
      .nq_i   (nq_s[i]),
      .valid_o(valid_s[i+1]),
      .ready_i(ready_s[i+1]),
      .ctl_o  (ctl_s[i+1]),
      .den_o  (den_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .nq_o   (nq_s[i+1])
    );
  end

  idiv_post #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk_i,
    .rst_ni,
    .valid_i(valid_s[DATA_WIDTH]),
    .ready_o(ready_s[DATA_WIDTH]),
    .ctl_i  (ctl_s[DATA_WIDTH]),
    .rem_i  (rem_s[DATA_WIDTH]),
    .quo_i  (nq_s[DATA_WIDTH]),
    .rsp_o
  );

endmodule

`default_nettype wire

/* rtl/core/idiv_chk.sv */
// ----------------------------------------------------------------------------
// idiv_chk
// Port-level checks of the divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_chk import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = IDIV_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_ready_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [DATA_WIDTH-1:0] rsp_result_i
);

  // hold a stalled response beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_result_i))
    else $error("response result changed while stalled");

  // an empty output stage opens the whole pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request side stalled with empty output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_ready_i |-> req_ready_i)
    else $error("request side stalled while response side drains");

endmodule

bind integer_divider_64_top idiv_chk #(
  .DATA_WIDTH(DATA_WIDTH)
) u_idiv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_result_i(rsp_o.result)
);

`default_nettype wire
